>>> design/bboc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bboc_pkg;

    // Widths of the sample, threshold, timer and result fields.
    localparam int LEVEL_W  = 12;
    localparam int TIMER_W  = 7;
    localparam int OCC_W    = 8;
    localparam int BEAMS    = 4;

    // Saturation ceiling of the people count and the width that holds it.
    localparam int COUNT_MAX = 255;
    localparam int COUNT_W   = $clog2(COUNT_MAX + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_A1_THR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A2_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B1_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B2_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOITER    = 3'd4;

    // Reset values of the registers.
    localparam logic [LEVEL_W-1:0] RST_A_THR      = 12'd1420;
    localparam logic [LEVEL_W-1:0] RST_B_THR      = 12'd1200;
    localparam logic [TIMER_W-1:0] RST_LOITER     = 7'd100;
    localparam logic [TIMER_W-1:0] TIMER_TOP      = 7'd127;

    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [TIMER_W-1:0] t_timer;
    typedef logic [COUNT_W-1:0] t_count;

    // One input item: four distance samples, order A1, A2, B1, B2.
    typedef struct packed {
        t_level pair_a_beam1_level;
        t_level pair_a_beam2_level;
        t_level pair_b_beam1_level;
        t_level pair_b_beam2_level;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [OCC_W-1:0] occupancy;
        logic             report_strobe;
        logic             entered;
        logic             departed;
    } t_out_item;

    // Classified sample set: bit k is beam k (A1, A2, B1, B2).
    typedef struct packed {
        logic [BEAMS-1:0] above;
        logic [BEAMS-1:0] below;
    } t_cls;

    // Front-to-back handshake.
    typedef struct packed {
        logic valid;
        t_cls cls;
    } t_front_out;

endpackage

`default_nettype wire

>>> design/bboc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bboc_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   push,
    output logic                  full,
    input  bboc_pkg::t_in_item    i_in_item,
    input  bboc_pkg::t_level      i_thr [bboc_pkg::BEAMS],
    output bboc_pkg::t_front_out  o_head,
    input  wire                   i_take
);

    logic [bboc_pkg::BEAMS-1:0] w_level_above;
    logic [bboc_pkg::BEAMS-1:0] w_level_below;
    bboc_pkg::t_level           w_lv [bboc_pkg::BEAMS];
    bboc_pkg::t_cls             r_mem [2];
    logic                       r_wp;
    logic                       r_rp;
    logic [1:0]                 r_cnt;
    logic [1:0]                 n_cnt;
    logic                       w_wr;
    logic                       w_rd;

    // Compare each sample strictly against its threshold in both directions.
    assign w_lv[0] = i_in_item.pair_a_beam1_level;
    assign w_lv[1] = i_in_item.pair_a_beam2_level;
    assign w_lv[2] = i_in_item.pair_b_beam1_level;
    assign w_lv[3] = i_in_item.pair_b_beam2_level;

    always_comb begin
        for (int k = 0; k < bboc_pkg::BEAMS; k++) begin
            w_level_above[k] = w_lv[k] > i_thr[k];
            w_level_below[k] = w_lv[k] < i_thr[k];
        end
    end

    // Two-entry queue of classified sample sets.
    assign full  = (r_cnt == 2'd2);
    assign w_wr  = push && !full;
    assign w_rd  = i_take && (r_cnt != 2'd0);
    assign n_cnt = r_cnt + {1'b0, w_wr} - {1'b0, w_rd};

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= '{above: w_level_above, below: w_level_below};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    // The head of the queue is offered to the back end.
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cls   = r_mem[r_rp];

endmodule

`default_nettype wire

>>> design/bboc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bboc_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  bboc_pkg::t_front_out   i_head,
    output logic                   o_take,
    input  bboc_pkg::t_timer       i_loiter_limit,
    output logic                   empty,
    input  wire                    pop,
    output bboc_pkg::t_out_item    o_out_item
);

    logic [bboc_pkg::BEAMS-1:0] r_latch;
    logic [bboc_pkg::BEAMS-1:0] n_latch;
    logic [bboc_pkg::BEAMS-1:0] r_seen;
    logic [bboc_pkg::BEAMS-1:0] n_seen;
    bboc_pkg::t_timer           r_tmr [bboc_pkg::BEAMS];
    bboc_pkg::t_timer           n_tmr [bboc_pkg::BEAMS];
    bboc_pkg::t_count           r_count;
    bboc_pkg::t_count           n_count;
    logic                       w_clr;
    logic                       w_up;
    logic                       w_dn;
    bboc_pkg::t_out_item        w_res;
    bboc_pkg::t_out_item        r_mem [2];
    logic                       r_wp;
    logic                       r_rp;
    logic [1:0]                 r_cnt;
    logic                       w_rd;

    // A running timer counts up once per sample set and holds at its top.
    function automatic bboc_pkg::t_timer tick(input bboc_pkg::t_timer t);
        if (t != '0 && t != bboc_pkg::TIMER_TOP) begin
            return t + bboc_pkg::t_timer'(1);
        end
        return t;
    endfunction

    // Whole update of one sample set: pair evaluation, cross pattern,
    // latch release and loiter check, in that order.
    always_comb begin
        logic [1:0] b1;
        logic [1:0] b2;
        n_tmr[0] = tick(r_tmr[0]);
        n_tmr[1] = tick(r_tmr[1]);
        n_tmr[2] = tick(r_tmr[2]);
        n_tmr[3] = tick(r_tmr[3]);
        n_latch  = r_latch;
        n_seen   = r_seen;
        n_count  = r_count;
        w_clr    = 1'b0;
        w_up     = 1'b0;
        w_dn     = 1'b0;
        b1       = 2'd0;
        b2       = 2'd1;

        for (int p = 0; p < 2; p++) begin
            b1 = {p[0], 1'b0};
            b2 = {p[0], 1'b1};
            if (i_head.cls.above[b1] && i_head.cls.below[b2] && !n_latch[b1]) begin
                n_tmr[b1]   = bboc_pkg::t_timer'(1);
                n_latch[b1] = 1'b1;
                if (n_seen[b2]) begin
                    w_dn = 1'b1;
                    if (n_count != '0) begin
                        n_count = n_count - bboc_pkg::t_count'(1);
                    end
                    n_seen[b1] = 1'b0;
                    n_seen[b2] = 1'b0;
                    n_tmr[b1]  = '0;
                    n_tmr[b2]  = '0;
                    w_clr      = 1'b1;
                end else begin
                    n_seen[b1] = 1'b1;
                end
            end else if (i_head.cls.below[b1] && i_head.cls.above[b2]
                         && !n_latch[b2]) begin
                n_tmr[b2]   = bboc_pkg::t_timer'(1);
                n_latch[b2] = 1'b1;
                if (n_seen[b1]) begin
                    w_up = 1'b1;
                    if (n_count != bboc_pkg::t_count'(bboc_pkg::COUNT_MAX)) begin
                        n_count = n_count + bboc_pkg::t_count'(1);
                    end
                    n_seen[b1] = 1'b0;
                    n_seen[b2] = 1'b0;
                    n_tmr[b1]  = '0;
                    n_tmr[b2]  = '0;
                    w_clr      = 1'b1;
                end else begin
                    n_seen[b2] = 1'b1;
                end
            end
        end

        // Cross-pair pattern: the first beam of one pair with the second
        // beam of the other counts as an entry and clears both pairs.
        if ((n_seen[0] && n_seen[3] && !n_seen[1] && !n_seen[2]) ||
            (n_seen[2] && n_seen[1] && !n_seen[0] && !n_seen[3])) begin
            w_up = 1'b1;
            if (n_count != bboc_pkg::t_count'(bboc_pkg::COUNT_MAX)) begin
                n_count = n_count + bboc_pkg::t_count'(1);
            end
            n_seen   = '0;
            n_tmr[0] = '0;
            n_tmr[1] = '0;
            n_tmr[2] = '0;
            n_tmr[3] = '0;
            w_clr    = 1'b1;
        end

        // A beam whose sample is below its threshold releases its latch.
        n_latch = n_latch & ~i_head.cls.below;

        // Abandon a half-finished crossing that has waited too long.
        for (int p = 0; p < 2; p++) begin
            b1 = {p[0], 1'b0};
            b2 = {p[0], 1'b1};
            if (n_tmr[b1] > i_loiter_limit || n_tmr[b2] > i_loiter_limit) begin
                if (n_tmr[b1] > i_loiter_limit) begin
                    n_latch[b1] = 1'b0;
                end else begin
                    n_latch[b2] = 1'b0;
                end
                n_seen[b1] = 1'b0;
                n_seen[b2] = 1'b0;
                n_tmr[b1]  = '0;
                n_tmr[b2]  = '0;
                w_clr      = 1'b1;
            end
        end

        w_res.occupancy     = bboc_pkg::OCC_W'(n_count);
        w_res.report_strobe = w_clr;
        w_res.entered       = w_up;
        w_res.departed      = w_dn;
    end

    // Take a sample set whenever the result queue has room.
    assign o_take = i_head.valid && (r_cnt != 2'd2);
    assign w_rd   = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= '0;
            r_seen  <= '0;
            r_count <= '0;
            for (int k = 0; k < bboc_pkg::BEAMS; k++) begin
                r_tmr[k] <= '0;
            end
        end else if (o_take) begin
            r_latch <= n_latch;
            r_seen  <= n_seen;
            r_count <= n_count;
            for (int k = 0; k < bboc_pkg::BEAMS; k++) begin
                r_tmr[k] <= n_tmr[k];
            end
        end
    end

    // Two-entry result queue.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_mem[r_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (o_take) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, o_take} - {1'b0, w_rd};
        end
    end

    assign empty      = (r_cnt == 2'd0);
    assign o_out_item = r_mem[r_rp];

    // The count never passes its ceiling.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bboc_pkg::t_count'(bboc_pkg::COUNT_MAX))
        else $error("people count above ceiling");

    // A finished crossing always clears a pair.
    a_entry_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && (w_up || w_dn)) |-> w_clr)
        else $error("count changed without clearing a pair");

    // Both beams of a pair are never marked as seen first together.
    a_seen_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_seen[0] && r_seen[1]) && !(r_seen[2] && r_seen[3]))
        else $error("both beams of a pair marked as first");

    // The count changes only on a transfer.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_take |=> $stable(r_count))
        else $error("count changed without a transfer");

    // The result queue never overfills.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue overfilled");

endmodule

`default_nettype wire

>>> design/bidirectional_beam_occupancy_counter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                             | Transfer
// ----------+-----------------------------------+------------------------
// samples   | push, full, i_in_item             | push && !full
// results   | empty, pop, o_out_item            | pop && !empty
// config    | i_cfg_we, i_cfg_idx, i_cfg_wdata  | i_cfg_we
//
// One sample set is classified on entry and updated in the back end, so a
// new set can be taken every cycle while the result queue has room.
// Each set is registered in the sample queue, its result in the result queue, before o_out_item.
// Reset is synchronous and active low; registers take their defaults.
// Each side has a two-entry queue, so either side may stall on its own;
// full rises once the sample queue holds two entries.
module bidirectional_beam_occupancy_counter (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  push,
    output logic                                 full,
    input  bboc_pkg::t_in_item                   i_in_item,
    output logic                                 empty,
    input  wire                                  pop,
    output bboc_pkg::t_out_item                  o_out_item,
    input  wire                                  i_cfg_we,
    input  wire  [bboc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [bboc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    bboc_pkg::t_level     r_thr [bboc_pkg::BEAMS];
    bboc_pkg::t_timer     r_loiter_limit;
    bboc_pkg::t_front_out w_head;
    logic                 w_take;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[0]       <= bboc_pkg::RST_A_THR;
            r_thr[1]       <= bboc_pkg::RST_A_THR;
            r_thr[2]       <= bboc_pkg::RST_B_THR;
            r_thr[3]       <= bboc_pkg::RST_B_THR;
            r_loiter_limit <= bboc_pkg::RST_LOITER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bboc_pkg::CFG_A1_THR: r_thr[0] <= i_cfg_wdata[bboc_pkg::LEVEL_W-1:0];
                bboc_pkg::CFG_A2_THR: r_thr[1] <= i_cfg_wdata[bboc_pkg::LEVEL_W-1:0];
                bboc_pkg::CFG_B1_THR: r_thr[2] <= i_cfg_wdata[bboc_pkg::LEVEL_W-1:0];
                bboc_pkg::CFG_B2_THR: r_thr[3] <= i_cfg_wdata[bboc_pkg::LEVEL_W-1:0];
                bboc_pkg::CFG_LOITER: begin
                    r_loiter_limit <= i_cfg_wdata[bboc_pkg::TIMER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end: threshold comparison and sample queue.
    bboc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .i_thr     (r_thr),
        .o_head    (w_head),
        .i_take    (w_take)
    );

    // Back end: crossing tracker, people count and result queue.
    bboc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .o_take         (w_take),
        .i_loiter_limit (r_loiter_limit),
        .empty          (empty),
        .pop            (pop),
        .o_out_item     (o_out_item)
    );

endmodule

`default_nettype wire

>>> sim/bidirectional_beam_occupancy_counter_test.sv
`timescale 1ns / 1ps

module bidirectional_beam_occupancy_counter_test;

    import bboc_pkg::*;

    localparam int LEVEL_TOP       = (1 << LEVEL_W) - 1;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 4;

    // An index above the last register; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    // Shape of one pair's two samples relative to that pair's thresholds.
    typedef enum {
        LV_IDLE, LV_FIRST, LV_SECOND, LV_BOTH, LV_EQUAL, LV_RAW, LV_FLOOR, LV_CEIL
    } t_shape;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  pop         = 1'b0;
    logic                  full;
    logic                  empty;
    t_in_item              i_in_item   = '0;
    t_out_item             o_out_item;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Shadow of the counter: thresholds, latches, timers and the head count.
    t_level    beam_thr [BEAMS];
    t_timer    loiter_lim;
    logic      tripped [BEAMS];
    t_timer    dwell [BEAMS];
    logic      first_seen [BEAMS];
    int        head_count;
    logic      cleared_flag;
    logic      raised_flag;
    logic      lowered_flag;

    t_in_item  queued_samples [$];
    t_out_item due_reports [$];
    t_shape    pair_plan [2][$];
    t_out_item due_report;

    int        send_wait     = 0;
    int        send_calm     = 0;
    int        take_wait     = 0;
    int        take_calm     = 0;
    int        reports_taken = 0;
    int        stall_cycles  = 0;
    int        error_count   = 0;

    // Opening sequence: extremes, both directions on each pair, a departure
    // at zero, a retrip while latched and both cross-pair patterns.
    t_shape opening_a [23] = '{
        LV_FLOOR, LV_CEIL, LV_EQUAL, LV_IDLE, LV_SECOND, LV_FIRST, LV_FIRST, LV_IDLE,
        LV_FIRST, LV_SECOND, LV_IDLE, LV_IDLE, LV_IDLE, LV_IDLE, LV_IDLE, LV_IDLE,
        LV_FIRST, LV_IDLE, LV_SECOND, LV_IDLE, LV_BOTH, LV_RAW, LV_FIRST
    };
    t_shape opening_b [23] = '{
        LV_FLOOR, LV_CEIL, LV_EQUAL, LV_IDLE, LV_IDLE, LV_IDLE, LV_IDLE, LV_IDLE,
        LV_IDLE, LV_IDLE, LV_FIRST, LV_SECOND, LV_IDLE, LV_SECOND, LV_FIRST, LV_IDLE,
        LV_SECOND, LV_IDLE, LV_FIRST, LV_IDLE, LV_BOTH, LV_RAW, LV_IDLE
    };

    bidirectional_beam_occupancy_counter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_error(input string what);
        $display("ERROR: %s", what);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Occupancy predictor
    // ---------------------------------------------------------------

    function automatic void reset_counter_state();
        beam_thr[0] = RST_A_THR;
        beam_thr[1] = RST_A_THR;
        beam_thr[2] = RST_B_THR;
        beam_thr[3] = RST_B_THR;
        loiter_lim  = RST_LOITER;
        for (int k = 0; k < BEAMS; k++) begin
            tripped[k]    = 1'b0;
            dwell[k]      = '0;
            first_seen[k] = 1'b0;
        end
        head_count = 0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx) inside
            CFG_A1_THR, CFG_A2_THR, CFG_B1_THR, CFG_B2_THR:
                beam_thr[idx[1:0]] = data[LEVEL_W-1:0];
            CFG_LOITER: loiter_lim = data[TIMER_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void count_enter();
        raised_flag = 1'b1;
        if (head_count < COUNT_MAX) head_count++;
    endfunction

    function automatic void count_leave();
        lowered_flag = 1'b1;
        if (head_count > 0) head_count--;
    endfunction

    function automatic void clear_pair(int base);
        first_seen[base]     = 1'b0;
        first_seen[base + 1] = 1'b0;
        dwell[base]          = '0;
        dwell[base + 1]      = '0;
        cleared_flag         = 1'b1;
    endfunction

    // A beam trips on a strict rise above its threshold while its partner is
    // strictly below; the second beam of a crossing decides the direction.
    function automatic void step_pair(int base, t_level l1, t_level l2);
        if (l1 > beam_thr[base] && l2 < beam_thr[base + 1] && !tripped[base]) begin
            dwell[base]   = t_timer'(1);
            tripped[base] = 1'b1;
            if (first_seen[base + 1]) begin
                count_leave();
                clear_pair(base);
            end else begin
                first_seen[base] = 1'b1;
            end
        end else if (l1 < beam_thr[base] && l2 > beam_thr[base + 1] && !tripped[base + 1]) begin
            dwell[base + 1]   = t_timer'(1);
            tripped[base + 1] = 1'b1;
            if (first_seen[base]) begin
                count_enter();
                clear_pair(base);
            end else begin
                first_seen[base + 1] = 1'b1;
            end
        end
    endfunction

    function automatic void loiter_check(int base);
        if (dwell[base] > loiter_lim) begin
            tripped[base] = 1'b0;
            clear_pair(base);
        end else if (dwell[base + 1] > loiter_lim) begin
            tripped[base + 1] = 1'b0;
            clear_pair(base);
        end
    endfunction

    function automatic t_out_item next_report(t_in_item s);
        t_level    lv [BEAMS];
        t_out_item r;
        lv[0] = s.pair_a_beam1_level;
        lv[1] = s.pair_a_beam2_level;
        lv[2] = s.pair_b_beam1_level;
        lv[3] = s.pair_b_beam2_level;
        cleared_flag = 1'b0;
        raised_flag  = 1'b0;
        lowered_flag = 1'b0;
        for (int k = 0; k < BEAMS; k++)
            if (dwell[k] != 0 && dwell[k] != TIMER_TOP) dwell[k]++;
        step_pair(0, lv[0], lv[1]);
        step_pair(2, lv[2], lv[3]);
        // Cross-pair pattern: a first beam of one pair and a second beam of the
        // other, with nothing else seen, counts as an entry.
        if ((first_seen[0] && first_seen[3] && !first_seen[1] && !first_seen[2]) ||
            (first_seen[2] && first_seen[1] && !first_seen[0] && !first_seen[3])) begin
            count_enter();
            clear_pair(0);
            clear_pair(2);
        end
        for (int k = 0; k < BEAMS; k++)
            if (lv[k] < beam_thr[k]) tripped[k] = 1'b0;
        loiter_check(0);
        loiter_check(2);
        r.occupancy     = head_count[OCC_W-1:0];
        r.report_strobe = cleared_flag;
        r.entered       = raised_flag;
        r.departed      = lowered_flag;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sample generation
    // ---------------------------------------------------------------

    function automatic t_level level_above(t_level th);
        int lo;
        int hi;
        if (th == LEVEL_TOP) return th;
        lo = int'(th) + 1;
        hi = ($urandom_range(0, 3) == 0) ? lo : LEVEL_TOP;
        return t_level'($urandom_range(hi, lo));
    endfunction

    function automatic t_level level_below(t_level th);
        int lo;
        int hi;
        if (th == 0) return th;
        hi = int'(th) - 1;
        lo = ($urandom_range(0, 3) == 0) ? hi : 0;
        return t_level'($urandom_range(hi, lo));
    endfunction

    function automatic void pair_levels(t_shape sh, t_level th1, t_level th2,
                                        output t_level l1, output t_level l2);
        case (sh)
            LV_IDLE: begin
                l1 = level_below(th1);
                l2 = level_below(th2);
            end
            LV_FIRST: begin
                l1 = level_above(th1);
                l2 = level_below(th2);
            end
            LV_SECOND: begin
                l1 = level_below(th1);
                l2 = level_above(th2);
            end
            LV_BOTH: begin
                l1 = level_above(th1);
                l2 = level_above(th2);
            end
            LV_EQUAL: begin
                l1 = th1;
                l2 = th2;
            end
            LV_FLOOR: begin
                l1 = '0;
                l2 = '0;
            end
            LV_CEIL: begin
                l1 = '1;
                l2 = '1;
            end
            default: begin
                l1 = t_level'($urandom_range(LEVEL_TOP, 0));
                l2 = t_level'($urandom_range(LEVEL_TOP, 0));
            end
        endcase
    endfunction

    function automatic t_in_item shape_item(t_shape sa, t_shape sb);
        t_in_item s;
        pair_levels(sa, beam_thr[0], beam_thr[1], s.pair_a_beam1_level, s.pair_a_beam2_level);
        pair_levels(sb, beam_thr[2], beam_thr[3], s.pair_b_beam1_level, s.pair_b_beam2_level);
        return s;
    endfunction

    function automatic void plan_shapes(int p, t_shape sh, int n);
        for (int i = 0; i < n; i++) pair_plan[p].push_back(sh);
    endfunction

    // One movement on a pair: an entry, a departure, an abandoned crossing
    // that waits out the loiter limit, or noise.
    function automatic void plan_move(int p, int enter_pct);
        int r;
        r = $urandom_range(99, 0);
        if (r < enter_pct) begin
            plan_shapes(p, LV_FIRST, $urandom_range(2, 1));
            plan_shapes(p, LV_SECOND, $urandom_range(2, 1));
            plan_shapes(p, LV_IDLE, $urandom_range(1, 0));
        end else if (r < 85) begin
            plan_shapes(p, LV_SECOND, $urandom_range(2, 1));
            plan_shapes(p, LV_FIRST, $urandom_range(2, 1));
            plan_shapes(p, LV_IDLE, $urandom_range(1, 0));
        end else if (r < 92) begin
            plan_shapes(p, (r % 2) ? LV_FIRST : LV_SECOND, 1);
            plan_shapes(p, LV_IDLE, int'(loiter_lim) + $urandom_range(3, 1));
        end else begin
            plan_shapes(p, t_shape'($urandom_range(int'(LV_CEIL), int'(LV_BOTH))),
                        $urandom_range(3, 1));
            plan_shapes(p, LV_IDLE, $urandom_range(1, 0));
        end
    endfunction

    task automatic fill_random(int count, int enter_pct);
        t_shape sa;
        t_shape sb;
        for (int i = 0; i < count; i++) begin
            if (pair_plan[0].size() == 0) plan_move(0, enter_pct);
            if (pair_plan[1].size() == 0) plan_move(1, enter_pct);
            sa = pair_plan[0].pop_front();
            sb = pair_plan[1].pop_front();
            queued_samples.push_back(shape_item(sa, sb));
        end
    endtask

    // Gap before the next transfer: mostly none or short, a few long, and
    // now and then a calm stretch with no gaps at all.
    function automatic int pick_gap(inout int calm_left);
        int r;
        r = $urandom_range(99, 0);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (r < 2) begin
            calm_left = $urandom_range(80, 20);
            return 0;
        end
        if (r < 62) return 0;
        if (r < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // ---------------------------------------------------------------
    // Configuration and phase control
    // ---------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        apply_register(idx, data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // The loiter limit is written with junk in the unused upper bits.
    task automatic set_thresholds(t_level a1, t_level a2, t_level b1, t_level b2, t_timer lim);
        write_reg(CFG_A1_THR, a1);
        write_reg(CFG_A2_THR, a2);
        write_reg(CFG_B1_THR, b1);
        write_reg(CFG_B2_THR, b2);
        write_reg(CFG_LOITER, CFG_DATA_W'(($urandom_range(31, 0) << TIMER_W) | lim));
    endtask

    function automatic t_level any_level(int lo, int hi);
        return t_level'($urandom_range(hi, lo));
    endfunction

    task automatic drain();
        while (queued_samples.size() != 0 || due_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Stimulus sequence
    // ---------------------------------------------------------------

    initial begin
        reset_counter_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values first: the opening sequence, then mixed traffic.
        @(negedge i_clk);
        for (int i = 0; i < 23; i++) queued_samples.push_back(shape_item(opening_a[i], opening_b[i]));
        fill_random(250, 45);
        drain();

        // Lowest thresholds and shortest loiter limit.
        set_thresholds('0, '0, '0, '0, 7'd1);
        @(negedge i_clk);
        fill_random(80, 45);
        drain();

        // Highest thresholds and longest loiter limit.
        set_thresholds('1, '1, '1, '1, 7'd126);
        @(negedge i_clk);
        fill_random(80, 45);
        drain();

        // Mostly entries, so the count runs into its ceiling.
        set_thresholds(any_level(100, 3900), any_level(100, 3900),
                       any_level(100, 3900), any_level(100, 3900),
                       t_timer'($urandom_range(126, 1)));
        write_reg(CFG_SPARE_IDX, any_level(0, LEVEL_TOP));
        @(negedge i_clk);
        fill_random(700, 80);
        drain();

        // Mostly departures with a short loiter limit, down to the floor.
        set_thresholds(any_level(0, LEVEL_TOP), any_level(0, LEVEL_TOP),
                       any_level(0, LEVEL_TOP), any_level(0, LEVEL_TOP),
                       t_timer'($urandom_range(10, 2)));
        @(negedge i_clk);
        fill_random(350, 10);
        drain();

        // Back to the usual thresholds.
        set_thresholds(RST_A_THR, RST_A_THR, RST_B_THR, RST_B_THR,
                       t_timer'($urandom_range(126, 1)));
        @(negedge i_clk);
        fill_random(300, 45);
        drain();

        if (error_count == 0) begin
            $display("bidirectional_beam_occupancy_counter_test: clean");
        end else begin
            $display("bidirectional_beam_occupancy_counter_test: errors");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Sample driver: each transfer is predicted as it happens.
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push      <= 1'b0;
            send_wait = 0;
        end else begin
            if (push && !full) begin
                due_reports.push_back(next_report(i_in_item));
                void'(queued_samples.pop_front());
                send_wait = pick_gap(send_calm);
            end else if (!push && send_wait > 0) begin
                send_wait--;
            end
            if (send_wait == 0 && queued_samples.size() != 0) begin
                push      <= 1'b1;
                i_in_item <= queued_samples[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: checks each transfer against the oldest prediction.
    // Twice in the run it holds off long enough for the block to fill.
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop       <= 1'b0;
            take_wait = 0;
        end else begin
            if (pop && !empty) begin
                if (due_reports.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing expected",
                                           reports_taken));
                end else begin
                    due_report = due_reports.pop_front();
                    if (o_out_item.occupancy !== due_report.occupancy)
                        report_error($sformatf("result %0d: occupancy %0d, expected %0d",
                                               reports_taken, o_out_item.occupancy,
                                               due_report.occupancy));
                    if (o_out_item.report_strobe !== due_report.report_strobe)
                        report_error($sformatf("result %0d: report_strobe %b, expected %b",
                                               reports_taken, o_out_item.report_strobe,
                                               due_report.report_strobe));
                    if (o_out_item.entered !== due_report.entered)
                        report_error($sformatf("result %0d: entered %b, expected %b",
                                               reports_taken, o_out_item.entered,
                                               due_report.entered));
                    if (o_out_item.departed !== due_report.departed)
                        report_error($sformatf("result %0d: departed %b, expected %b",
                                               reports_taken, o_out_item.departed,
                                               due_report.departed));
                end
                reports_taken++;
                if (reports_taken == 800 || reports_taken == 1500)
                    take_wait = HOLD_OFF_CYCLES;
                else
                    take_wait = pick_gap(take_calm);
            end else if (!pop && take_wait > 0) begin
                take_wait--;
            end
            pop <= (take_wait == 0);
        end
    end

    // Watchdog: work outstanding but no transfer on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n && (queued_samples.size() != 0 || due_reports.size() != 0) &&
            !(push && !full) && !(pop && !empty)) begin
            stall_cycles++;
        end else begin
            stall_cycles = 0;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("bidirectional_beam_occupancy_counter_test: errors");
            $finish;
        end
    end

endmodule
